// ===== design/sfbc_pkg.sv =====
// Shared types and constants for the SFBC transmit-diversity precoder.
// Used by sfbc_sym_scaler and sfbc_transmit_diversity_precoder_top; no dependencies.
package sfbc_pkg;

    // Sample width of one real or imaginary part, signed Q1.(SAMPLE_W-1).
    localparam int SAMPLE_W = 16;

    // 1/sqrt(2) in Q1.31.
    localparam logic [30:0] INV_SQRT2_Q31 = 31'd1518500250;

    // Signed product of a sample and the Q1.31 scale factor.
    localparam int PROD_W = SAMPLE_W + 32;

    // Symbols per group in four-port mode, and symbols held while a group fills.
    localparam int GROUP_MAX = 4;
    localparam int STORE_DEPTH = GROUP_MAX - 1;
    localparam int SLOT_W = 2;

    // Finished groups waiting for the column emitter (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Number of antenna ports carried in every output beat.
    localparam int NUM_PORTS = 4;
    localparam int OUT_DATA_W = 2 * SAMPLE_W * NUM_PORTS;

    // Control that travels with a symbol through the scaling pipeline.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;   // position of the symbol inside its group
        logic              close;  // this symbol finishes the group
        logic              wide;   // group emits four columns
        logic              four;   // group was built in four-port mode
        logic              last;   // group was closed by the end of a codeword
    } sym_ctrl_t;

    // One symbol scaled by 1/sqrt(2), both with its own sign and negated.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pos_re;
        logic signed [SAMPLE_W-1:0] pos_im;
        logic signed [SAMPLE_W-1:0] neg_re;
        logic signed [SAMPLE_W-1:0] neg_im;
    } scaled_t;

    // A finished group as held in the column queue.
    typedef struct packed {
        scaled_t [GROUP_MAX-1:0] sym;
        logic                    wide;
        logic                    four;
        logic                    last;
    } group_t;

    // One complex output sample of one antenna port.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] im;
        logic signed [SAMPLE_W-1:0] re;
    } port_val_t;

endpackage

// ===== design/sfbc_sym_scaler.sv =====
// Two-stage scaling pipeline: input register, 1/sqrt(2) multiply, round and saturate.
// Depends on sfbc_pkg for the sample width, scale constant and control struct.
module sfbc_sym_scaler import sfbc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sym_ctrl_t                  in_ctrl,
    input  logic signed [SAMPLE_W-1:0] in_re,
    input  logic signed [SAMPLE_W-1:0] in_im,
    output sym_ctrl_t                  out_ctrl,
    output scaled_t                    out_val
);

    localparam int SHIFT_W = PROD_W + 1 - 31;

    sym_ctrl_t                  ctrl1_reg;
    logic signed [SAMPLE_W-1:0] re1_reg;
    logic signed [SAMPLE_W-1:0] im1_reg;
    sym_ctrl_t                  ctrl2_reg;
    logic signed [PROD_W-1:0]   prod_re_reg;
    logic signed [PROD_W-1:0]   prod_im_reg;
    logic signed [PROD_W-1:0]   prod_re_next;
    logic signed [PROD_W-1:0]   prod_im_next;

    // Round to nearest (ties up) after the Q1.31 shift, then clamp to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W:0] v
    );
        logic signed [PROD_W:0]    sum;
        logic signed [SHIFT_W-1:0] sh;
        logic [SHIFT_W-SAMPLE_W:0] top;
        logic signed [SAMPLE_W-1:0] res;
        sum = v + {{(PROD_W - 30){1'b0}}, 1'b1, 30'd0};
        sh  = sum[PROD_W:31];
        top = sh[SHIFT_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            res = sh[SAMPLE_W-1:0];
        end else if (sh[SHIFT_W-1]) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Exact products with the positive scale factor.
    assign prod_re_next = PROD_W'(re1_reg) * PROD_W'(signed'({1'b0, INV_SQRT2_Q31}));
    assign prod_im_next = PROD_W'(im1_reg) * PROD_W'(signed'({1'b0, INV_SQRT2_Q31}));

    // Control travels beside the samples; only the valid bit needs reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else begin
            ctrl1_reg <= in_ctrl;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    // Sample and product registers.
    always_ff @(posedge aclk) begin
        re1_reg     <= in_re;
        im1_reg     <= in_im;
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
    end

    // Negating the product before rounding gives the exact scale of the negated input.
    always_comb begin
        out_ctrl       = ctrl2_reg;
        out_val.pos_re = round_sat({prod_re_reg[PROD_W-1], prod_re_reg});
        out_val.pos_im = round_sat({prod_im_reg[PROD_W-1], prod_im_reg});
        out_val.neg_re = round_sat(-{prod_re_reg[PROD_W-1], prod_re_reg});
        out_val.neg_im = round_sat(-{prod_im_reg[PROD_W-1], prod_im_reg});
    end

endmodule

// ===== design/sfbc_transmit_diversity_precoder_top.sv =====
// Path: a group's closing beat passes the scaler registers, the queue and the output register.
// Throughput: one input beat per cycle while a queue slot is free and one output column per
// cycle while m_tready is high; a four-entry queue of finished groups feeds the column
// emitter, so single-symbol tails that emit two columns hold back input only once it is full.
// Reset: aresetn is synchronous, active low; it clears the mode register, the group fill,
// the pipeline and the queue. Held symbols are not cleared.
//
// Top level of the SFBC transmit-diversity precoder.
// Depends on sfbc_pkg and sfbc_sym_scaler.
module sfbc_transmit_diversity_precoder_top import sfbc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Mode register write: bit 0 is four_port_mode.
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    // Input symbol stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*SAMPLE_W-1:0] s_tdata,  // [15:0] sym_re, [31:16] sym_im
    input  logic                  s_tlast,  // last_in
    // Output column stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // port0_re, port0_im, port1_re, port1_im,
                                            // port2_re, port2_im, port3_re, port3_im
    output logic                  m_tlast   // last_out
);

    logic                  four_port_reg;
    logic [SLOT_W-1:0]     fill_reg;
    logic [SLOT_W-1:0]     fill_next;
    logic [QCNT_W-1:0]     credit_reg;
    logic [QCNT_W-1:0]     credit_next;

    logic                  accept;
    logic [SLOT_W-1:0]     dec_slot;
    logic                  dec_close;
    logic                  dec_wide;
    sym_ctrl_t             in_ctrl;

    sym_ctrl_t             st_ctrl;
    scaled_t               st_val;
    scaled_t               stg_reg [STORE_DEPTH];
    group_t                grp_new;
    logic                  push;

    group_t                q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QCNT_W-1:0]     q_count_reg;
    group_t                head;

    logic [1:0]            col_reg;
    logic                  load;
    logic                  last_col;
    logic                  pop;
    scaled_t               sym_a;
    scaled_t               sym_b;
    port_val_t             prim_val;
    port_val_t             sec_val;
    logic [1:0]            prim_port;
    logic [1:0]            sec_port;
    port_val_t [NUM_PORTS-1:0] col_ports;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_last_reg;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_port_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            four_port_reg <= cfg_wr_data;
        end
    end

    // A beat may enter whenever a queue slot is still free for the group it might close.
    assign s_tready = (credit_reg != '0);
    assign accept   = s_tvalid && s_tready;

    // Place the incoming symbol in its group and decide whether the group is finished.
    always_comb begin
        if (four_port_reg) begin
            dec_slot  = fill_reg;
            dec_close = s_tlast || (fill_reg == SLOT_W'(GROUP_MAX - 1));
            dec_wide  = fill_reg[1];
        end else if (fill_reg != '0) begin
            dec_slot  = SLOT_W'(1);
            dec_close = 1'b1;
            dec_wide  = 1'b0;
        end else begin
            dec_slot  = '0;
            dec_close = s_tlast;
            dec_wide  = 1'b0;
        end
        fill_next     = dec_close ? '0 : dec_slot + SLOT_W'(1);
        in_ctrl.valid = accept;
        in_ctrl.slot  = dec_slot;
        in_ctrl.close = dec_close;
        in_ctrl.wide  = dec_wide;
        in_ctrl.four  = four_port_reg;
        in_ctrl.last  = s_tlast;
    end

    // Group fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    sfbc_sym_scaler u_scaler (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctrl  (in_ctrl),
        .in_re    (s_tdata[SAMPLE_W-1:0]),
        .in_im    (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .out_ctrl (st_ctrl),
        .out_val  (st_val)
    );

    // Held symbols of the group being gathered, stored already scaled.
    always_ff @(posedge aclk) begin
        if (st_ctrl.valid && !st_ctrl.close && (st_ctrl.slot != SLOT_W'(STORE_DEPTH))) begin
            stg_reg[st_ctrl.slot] <= st_val;
        end
    end

    // Assemble the finished group; slots past the closing symbol are zero padding.
    always_comb begin
        grp_new      = '0;
        grp_new.wide = st_ctrl.wide;
        grp_new.four = st_ctrl.four;
        grp_new.last = st_ctrl.last;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (SLOT_W'(i) < st_ctrl.slot) begin
                grp_new.sym[i] = stg_reg[i];
            end
        end
        grp_new.sym[st_ctrl.slot] = st_val;
    end

    assign push = st_ctrl.valid && st_ctrl.close;

    // Queue of finished groups.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= grp_new;
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign load     = (q_count_reg != '0) && (!m_valid_reg || m_tready);
    assign last_col = head.wide ? (col_reg == 2'd3) : (col_reg == 2'd1);
    assign pop      = load && last_col;

    // Queue pointers, occupancy, and slot credits handed back when a group is fully sent.
    always_comb begin
        credit_next = credit_reg;
        if (pop) begin
            credit_next = credit_next + QCNT_W'(1);
        end
        if (accept && dec_close) begin
            credit_next = credit_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            credit_reg  <= QCNT_W'(QUEUE_DEPTH);
            col_reg     <= '0;
        end else begin
            credit_reg <= credit_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                q_count_reg <= q_count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                q_count_reg <= q_count_reg - QCNT_W'(1);
            end
            if (load) begin
                col_reg <= last_col ? 2'd0 : col_reg + 2'd1;
            end
        end
    end

    // Build one column: the upper column pair of a four-port group uses the second symbol pair.
    always_comb begin
        sym_a     = head.sym[{col_reg[1], 1'b0}];
        sym_b     = head.sym[{col_reg[1], 1'b1}];
        prim_port = {1'b0, col_reg[1]};
        sec_port  = head.four ? {1'b1, col_reg[1]} : 2'd1;
        if (col_reg[0]) begin
            prim_val.re = sym_b.pos_re;
            prim_val.im = sym_b.pos_im;
            sec_val.re  = sym_a.pos_re;
            sec_val.im  = sym_a.neg_im;
        end else begin
            prim_val.re = sym_a.pos_re;
            prim_val.im = sym_a.pos_im;
            sec_val.re  = sym_b.neg_re;
            sec_val.im  = sym_b.pos_im;
        end
        col_ports            = '0;
        col_ports[prim_port] = prim_val;
        col_ports[sec_port]  = sec_val;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= col_ports;
            m_last_reg <= head.last && last_col;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Credits and queued groups together never exceed the queue size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (QCNT_W + 1)'(credit_reg) + (QCNT_W + 1)'(q_count_reg) <= (QCNT_W + 1)'(QUEUE_DEPTH))
        else $error("credit and queue occupancy exceed queue depth");

    // A finished group never arrives at a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count_reg != QCNT_W'(QUEUE_DEPTH)))
        else $error("group pushed into a full queue");

    // The emitter only walks columns of a queued group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg != 2'd0) |-> (q_count_reg != '0))
        else $error("column index advanced with no group queued");

    // Two-port groups never reach the upper column pair.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((q_count_reg != '0) && !head.wide) |-> !col_reg[1])
        else $error("two-column group walked past its second column");

    // A closed group always leaves the fill count empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dec_close) |=> (fill_reg == '0))
        else $error("fill count not cleared after a group closed");

endmodule

// ===== tb/sfbc_transmit_diversity_precoder_top_tb.sv =====
// Self-checking testbench for the SFBC transmit-diversity precoder top level.
// Depends on sfbc_pkg and sfbc_transmit_diversity_precoder_top; predicts every output column.
`timescale 1ns / 1ps

module sfbc_transmit_diversity_precoder_top_tb;
    import sfbc_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       last;
    } symbol_t;

    typedef struct {
        logic [OUT_DATA_W-1:0] data;
        logic                  last;
    } column_t;

    localparam longint SCALE_Q31 = 64'sd1518500250;
    localparam int DRAIN_CYCLES = 8;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_wr_data = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*SAMPLE_W-1:0] s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Pending input symbols and columns still owed by the block.
    symbol_t sym_queue[$];
    column_t column_queue[$];
    int      mismatch_count = 0;

    // Predictor copy of the mode register and of the partly filled group.
    bit      mode_four = 1'b0;
    longint  held_re[STORE_DEPTH];
    longint  held_im[STORE_DEPTH];
    int      held_cnt = 0;

    // Flow control state of the sender and receiver.
    logic    idle_on = 1'b1;
    int      tx_gap = 0;
    symbol_t tx_sym;
    int      rx_stall_left = 0;
    logic    rx_long_hold = 1'b0;
    logic    rx_long_done = 1'b0;

    string port_field_name[2*NUM_PORTS] = '{"port0_re", "port0_im", "port1_re", "port1_im",
                                            "port2_re", "port2_im", "port3_re", "port3_im"};

    sfbc_transmit_diversity_precoder_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Multiply by 1/sqrt(2) in Q1.31, round half up, saturate to the sample range.
    function automatic logic [SAMPLE_W-1:0] scale_by_recip_sqrt2(longint v);
        longint prod;
        prod = (v * SCALE_Q31 + (64'sd1 <<< 30)) >>> 31;
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        return prod[SAMPLE_W-1:0];
    endfunction

    // Queue one expected column holding two active ports; the other ports stay zero.
    function automatic void expect_column(int pa, longint a_re, longint a_im,
                                          int pb, longint b_re, longint b_im, logic lst);
        column_t col;
        col.data = '0;
        col.data[2*SAMPLE_W*pa +: SAMPLE_W] = scale_by_recip_sqrt2(a_re);
        col.data[2*SAMPLE_W*pa+SAMPLE_W +: SAMPLE_W] = scale_by_recip_sqrt2(a_im);
        col.data[2*SAMPLE_W*pb +: SAMPLE_W] = scale_by_recip_sqrt2(b_re);
        col.data[2*SAMPLE_W*pb+SAMPLE_W +: SAMPLE_W] = scale_by_recip_sqrt2(b_im);
        col.last = lst;
        column_queue.push_back(col);
    endfunction

    // Layer mapping and SFBC precoding of one accepted symbol.
    function automatic void precode_symbol(logic signed [SAMPLE_W-1:0] re,
                                           logic signed [SAMPLE_W-1:0] im, logic lst);
        longint g_re[GROUP_MAX];
        longint g_im[GROUP_MAX];
        int     n;
        int     size;
        for (int i = 0; i < GROUP_MAX; i++) begin
            g_re[i] = 0;
            g_im[i] = 0;
        end
        if (mode_four) begin
            for (int i = 0; i < held_cnt; i++) begin
                g_re[i] = held_re[i];
                g_im[i] = held_im[i];
            end
            g_re[held_cnt] = re;
            g_im[held_cnt] = im;
            n = held_cnt + 1;
            size = 4;
        end else if (held_cnt != 0) begin
            // A two-port pair always takes the oldest held symbol.
            g_re[0] = held_re[0];
            g_im[0] = held_im[0];
            g_re[1] = re;
            g_im[1] = im;
            n = 2;
            size = 2;
        end else begin
            g_re[0] = re;
            g_im[0] = im;
            n = 1;
            size = 2;
        end

        if (n < size && !lst) begin
            held_re[n-1] = re;
            held_im[n-1] = im;
            held_cnt = n;
            return;
        end

        if (!mode_four) begin
            expect_column(0, g_re[0], g_im[0], 1, -g_re[1], g_im[1], 1'b0);
            expect_column(0, g_re[1], g_im[1], 1, g_re[0], -g_im[0], lst);
        end else begin
            // Short tails of one or two symbols emit only the first two columns.
            expect_column(0, g_re[0], g_im[0], 2, -g_re[1], g_im[1], 1'b0);
            expect_column(0, g_re[1], g_im[1], 2, g_re[0], -g_im[0], lst && n <= 2);
            if (n > 2) begin
                expect_column(1, g_re[2], g_im[2], 3, -g_re[3], g_im[3], 1'b0);
                expect_column(1, g_re[3], g_im[3], 3, g_re[2], -g_im[2], lst);
            end
        end
        held_cnt = 0;
    endfunction

    // Compare one output beat against the oldest expected column.
    task automatic check_column();
        column_t exp_col;
        if (column_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected output beat, data %h", m_tdata));
            return;
        end
        exp_col = column_queue.pop_front();
        for (int f = 0; f < 2*NUM_PORTS; f++) begin
            if (m_tdata[SAMPLE_W*f +: SAMPLE_W] !== exp_col.data[SAMPLE_W*f +: SAMPLE_W])
                report_mismatch($sformatf("%s got %h expected %h", port_field_name[f],
                                          m_tdata[SAMPLE_W*f +: SAMPLE_W],
                                          exp_col.data[SAMPLE_W*f +: SAMPLE_W]));
        end
        if (m_tlast !== exp_col.last)
            report_mismatch($sformatf("last_out got %b expected %b", m_tlast, exp_col.last));
    endtask

    // Sender: presents queued symbols, with random idle bursts between beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (idle_on && tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (sym_queue.size() != 0) begin
                tx_sym = sym_queue.pop_front();
                s_tdata <= {tx_sym.im, tx_sym.re};
                s_tlast <= tx_sym.last;
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    tx_gap <= $urandom_range(1, 13);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall_left <= 0;
        end else if (rx_long_hold && !rx_long_done) begin
            rx_long_done <= 1'b1;
            rx_stall_left <= 400;
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on every input beat, check on every output beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                precode_symbol(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W], s_tlast);
            if (m_tvalid && m_tready)
                check_column();
        end
    end

    task automatic queue_symbol(int re, int im, logic lst);
        symbol_t sym;
        sym.re = SAMPLE_W'(re);
        sym.im = SAMPLE_W'(im);
        sym.last = lst;
        sym_queue.push_back(sym);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        unique case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Random codewords of 1 to 9 symbols; a few run on without an end marker.
    task automatic queue_codewords(int count);
        int len;
        int queued;
        queued = 0;
        while (queued < count) begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
                queue_symbol(int'($signed(rand_sample())), int'($signed(rand_sample())),
                             i == len - 1 && $urandom_range(0, 5) != 0);
            queued += len;
        end
    endtask

    // Wait until every symbol is accepted and every column has arrived.
    task automatic wait_for_drain();
        @(negedge aclk);
        while (sym_queue.size() != 0 || s_tvalid || column_queue.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_port_mode(bit four);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= four;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_four = four;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Two-port groups at the sample extremes, then a single-symbol tail.
        queue_symbol(32767, -32768, 1'b0);
        queue_symbol(-32768, 32767, 1'b0);
        queue_symbol(-32768, -32768, 1'b0);
        queue_symbol(32767, 32767, 1'b1);
        queue_symbol(-1, 1, 1'b1);
        // Leave one symbol held across the switch to four ports.
        queue_symbol(12345, -23456, 1'b0);
        wait_for_drain();
        set_port_mode(1'b1);

        // The held symbol opens a four-port group.
        queue_symbol(-32768, 32767, 1'b0);
        queue_symbol(32767, -32768, 1'b0);
        queue_symbol(-1, -1, 1'b0);
        // Full group closed by the codeword end.
        queue_symbol(32767, 32767, 1'b0);
        queue_symbol(-32768, -32768, 1'b0);
        queue_symbol(0, 0, 1'b0);
        queue_symbol(1, -1, 1'b1);
        // Two-symbol tail, one-symbol tail, three-symbol tail.
        queue_symbol(20000, -20000, 1'b0);
        queue_symbol(-32768, 5, 1'b1);
        queue_symbol(32767, -32768, 1'b1);
        queue_symbol(-7, 32767, 1'b0);
        queue_symbol(100, -100, 1'b0);
        queue_symbol(-32768, -1, 1'b1);
        // Two symbols held, then back to two ports: the oldest one pairs.
        queue_symbol(4096, -4096, 1'b0);
        queue_symbol(777, 888, 1'b0);
        wait_for_drain();
        set_port_mode(1'b0);
        queue_symbol(-32768, 32767, 1'b1);
        wait_for_drain();

        // Three symbols held in four-port mode, then a two-port pair.
        set_port_mode(1'b1);
        queue_symbol(-32768, 0, 1'b0);
        queue_symbol(0, -32768, 1'b0);
        queue_symbol(32767, 1, 1'b0);
        wait_for_drain();
        set_port_mode(1'b0);
        queue_symbol(-2, 32767, 1'b0);
        wait_for_drain();

        // Random codewords; the first phase backs the block up behind a long output hold.
        set_port_mode(1'b1);
        rx_long_hold <= 1'b1;
        queue_codewords(30);
        wait_for_drain();

        set_port_mode(1'b0);
        queue_codewords(20);
        wait_for_drain();

        set_port_mode(1'b1);
        queue_codewords(20);
        wait_for_drain();

        // Closing phase at full rate on both sides.
        set_port_mode(1'b0);
        idle_on <= 1'b0;
        queue_codewords(20);
        wait_for_drain();

        if (mismatch_count == 0 && column_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
